/* design/eyvm_pkg.sv */
package eyvm_pkg;

	// Field widths
	localparam int ANGLE_BITS = 16;
	localparam int COORD_BITS = 32;
	localparam int ROT_W      = 16;
	localparam int ONE_Q14    = 16384;

	// Packed beat widths, padded to whole bytes
	localparam int IN_W        = 3 * COORD_BITS + 3 * ANGLE_BITS;
	localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W       = 9 * ROT_W + 3 * COORD_BITS;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	// Pipeline depth: sine 7, rotation 3, translation 2
	localparam int NSTAGE = 12;

	// Quarter-wave odd polynomial coefficients, Q30
	localparam logic [31:0] Q30_C1 = 32'd1686629713;
	localparam logic [31:0] Q30_C3 = 32'd693598669;
	localparam logic [31:0] Q30_C5 = 32'd85569306;
	localparam logic [31:0] Q30_C7 = 32'd5026994;
	localparam logic [31:0] Q30_C9 = 32'd172272;

	typedef logic signed [ROT_W-1:0]      rot_t;
	typedef logic [8:0][ROT_W-1:0]        rot_vec_t;
	typedef logic [2:0][COORD_BITS-1:0]   coord_vec_t;
	typedef logic [NSTAGE-1:0]            stage_en_t;

endpackage

/* design/eyvm_sine.sv */
module eyvm_sine (
	input  logic                            clk,
	input  logic [6:0]                      en,
	input  logic [eyvm_pkg::ANGLE_BITS-1:0] phase,
	output eyvm_pkg::rot_t                  value
);
	localparam int AB   = eyvm_pkg::ANGLE_BITS;
	localparam int X_SH = 32 - AB;
	localparam logic [AB-2:0] QUARTER = (AB-1)'(1 << (AB - 2));

	logic [1:0]    quad;
	logic [AB-2:0] t;

	logic [30:0] x_s1, x_s2, x_s3, x_s4, x_s5, x_s6;
	logic        neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic [31:0] x2_s2, x2_s3, x2_s4, x2_s5;
	logic [31:0] acc_s3, acc_s4, acc_s5, acc_s6;
	eyvm_pkg::rot_t value_s7;

	logic [63:0] sq, p3, p4, p5, p6, py;
	logic [33:0] y;
	logic [17:0] r;
	logic [14:0] mag;

	// fold the angle onto the first quadrant
	always_comb begin
		quad = phase[AB-1:AB-2];
		t    = quad[0] ? (QUARTER - {1'b0, phase[AB-3:0]}) : {1'b0, phase[AB-3:0]};
	end

	always_comb begin
		sq = 64'(x_s1) * 64'(x_s1);
		p3 = 64'(x2_s2) * 64'(eyvm_pkg::Q30_C9);
		p4 = 64'(x2_s3) * 64'(acc_s3);
		p5 = 64'(x2_s4) * 64'(acc_s4);
		p6 = 64'(x2_s5) * 64'(acc_s5);
		py = 64'(x_s6) * 64'(acc_s6);
		y  = py[63:30];
		r  = 18'((y + 34'd32768) >> 16);
		mag = (r > 18'(eyvm_pkg::ONE_Q14)) ? 15'(eyvm_pkg::ONE_Q14) : r[14:0];
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			x_s1   <= 31'(t) << X_SH;
			neg_s1 <= quad[1];
		end
		if (en[1]) begin
			x2_s2  <= sq[61:30];
			x_s2   <= x_s1;
			neg_s2 <= neg_s1;
		end
		if (en[2]) begin
			acc_s3 <= eyvm_pkg::Q30_C7 - p3[61:30];
			x2_s3  <= x2_s2;
			x_s3   <= x_s2;
			neg_s3 <= neg_s2;
		end
		if (en[3]) begin
			acc_s4 <= eyvm_pkg::Q30_C5 - p4[61:30];
			x2_s4  <= x2_s3;
			x_s4   <= x_s3;
			neg_s4 <= neg_s3;
		end
		if (en[4]) begin
			acc_s5 <= eyvm_pkg::Q30_C3 - p5[61:30];
			x2_s5  <= x2_s4;
			x_s5   <= x_s4;
			neg_s5 <= neg_s4;
		end
		if (en[5]) begin
			acc_s6 <= eyvm_pkg::Q30_C1 - p6[61:30];
			x_s6   <= x_s5;
			neg_s6 <= neg_s5;
		end
		if (en[6]) begin
			value_s7 <= neg_s6 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end
	end

	assign value = value_s7;

endmodule

/* design/eyvm_rot.sv */
module eyvm_rot (
	input  logic               clk,
	input  logic [2:0]         en,
	input  eyvm_pkg::rot_t     s1,
	input  eyvm_pkg::rot_t     c1,
	input  eyvm_pkg::rot_t     s2,
	input  eyvm_pkg::rot_t     c2,
	input  eyvm_pkg::rot_t     s3,
	input  eyvm_pkg::rot_t     c3,
	output eyvm_pkg::rot_vec_t rot
);
	// pair products, Q28
	logic signed [31:0] c1c3_s8, s1s2_s8, c2s3_s8, c1s2_s8, c3s1_s8;
	logic signed [31:0] c1s3_s8, c2c3_s8, s1s3_s8, c2s1_s8, c1c2_s8;
	eyvm_pkg::rot_t s2_s8, s3_s8, c3_s8;
	// entry sums, Q42
	logic signed [45:0] q_s9 [9];
	eyvm_pkg::rot_vec_t rot_s10;

	logic signed [45:0] q [9];

	// round Q42 to Q14 half away from zero, clamp to one
	function automatic eyvm_pkg::rot_t round_rot(input logic signed [45:0] v);
		logic [45:0] m;
		logic [17:0] r;
		logic [14:0] c;
		m = v[45] ? 46'(-v) : 46'(v);
		r = 18'((m + 46'(1 << 27)) >> 28);
		c = (r > 18'(eyvm_pkg::ONE_Q14)) ? 15'(eyvm_pkg::ONE_Q14) : r[14:0];
		return v[45] ? -$signed({1'b0, c}) : $signed({1'b0, c});
	endfunction

	always_comb begin
		q[0] = (46'(c1c3_s8) <<< 14) + 46'(s1s2_s8) * 46'(s3_s8);
		q[1] =  46'(c2s3_s8) <<< 14;
		q[2] =  46'(c1s2_s8) * 46'(s3_s8) - (46'(c3s1_s8) <<< 14);
		q[3] =  46'(s1s2_s8) * 46'(c3_s8) - (46'(c1s3_s8) <<< 14);
		q[4] =  46'(c2c3_s8) <<< 14;
		q[5] =  46'(c1s2_s8) * 46'(c3_s8) + (46'(s1s3_s8) <<< 14);
		q[6] =  46'(c2s1_s8) <<< 14;
		q[7] = -(46'(s2_s8) <<< 28);
		q[8] =  46'(c1c2_s8) <<< 14;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			c1c3_s8 <= c1 * c3;
			s1s2_s8 <= s1 * s2;
			c2s3_s8 <= c2 * s3;
			c1s2_s8 <= c1 * s2;
			c3s1_s8 <= c3 * s1;
			c1s3_s8 <= c1 * s3;
			c2c3_s8 <= c2 * c3;
			s1s3_s8 <= s1 * s3;
			c2s1_s8 <= c2 * s1;
			c1c2_s8 <= c1 * c2;
			s2_s8   <= s2;
			s3_s8   <= s3;
			c3_s8   <= c3;
		end
		if (en[1]) begin
			q_s9 <= q;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < 9; i++) begin
				rot_s10[i] <= round_rot(q_s9[i]);
			end
		end
	end

	assign rot = rot_s10;

endmodule

/* design/eyvm_shift.sv */
module eyvm_shift (
	input  logic                 clk,
	input  logic [1:0]           en,
	input  eyvm_pkg::rot_vec_t   rot_in,
	input  eyvm_pkg::coord_vec_t pos,
	output eyvm_pkg::rot_vec_t   rot_out,
	output eyvm_pkg::coord_vec_t shift
);
	localparam int CB  = eyvm_pkg::COORD_BITS;
	localparam int PW  = CB + 16;
	localparam int DW  = CB + 18;
	localparam int RW  = CB + 5;
	localparam logic [RW-1:0] MAXP = RW'((64'd1 << (CB - 1)) - 64'd1);

	logic signed [PW-1:0] prod_s11 [9];
	eyvm_pkg::rot_vec_t   rot_s11, rot_s12;
	eyvm_pkg::coord_vec_t shift_s12;
	eyvm_pkg::coord_vec_t sat;

	// negate the dot, round Q30 to Q16 half away from zero, saturate
	function automatic logic [CB-1:0] sat_row(input logic signed [PW-1:0] a,
		input logic signed [PW-1:0] b, input logic signed [PW-1:0] c);
		logic signed [DW-1:0] nd;
		logic [DW-1:0] m;
		logic [RW-1:0] r;
		logic [CB-1:0] o;
		nd = -(DW'(a) + DW'(b) + DW'(c));
		m  = nd[DW-1] ? DW'(-nd) : DW'(nd);
		r  = RW'((m + DW'(1 << 13)) >> 14);
		if (!nd[DW-1]) begin
			o = (r > MAXP) ? MAXP[CB-1:0] : r[CB-1:0];
		end else begin
			o = (r > MAXP + RW'(1)) ? CB'(-(MAXP + RW'(1))) : CB'(-r);
		end
		return o;
	endfunction

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sat[i] = sat_row(prod_s11[3*i], prod_s11[3*i+1], prod_s11[3*i+2]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 9; i++) begin
				prod_s11[i] <= PW'($signed(rot_in[i])) * PW'($signed(pos[i % 3]));
			end
			rot_s11 <= rot_in;
		end
		if (en[1]) begin
			shift_s12 <= sat;
			rot_s12   <= rot_s11;
		end
	end

	assign rot_out = rot_s12;
	assign shift   = shift_s12;

endmodule

/* design/euler_yxz_view_matrix.sv */
// View matrix from a camera pose. Each s_ beat carries a position (Q16.16)
// and yaw, pitch, roll binary angles (half a turn = 2^(ANGLE_BITS-1)); each
// m_ beat returns the YXZ rotation basis u (right), v (up), w (forward) as
// Q1.14 entries and the translations -(u.p), -(v.p), -(w.p) as saturated
// Q16.16. One beat is taken per clock unless m_ back-pressure fills the
// pipe; stages in order: sine/cosine polynomial (six units, one per sine and
// cosine), rotation products and rounding, dot products and saturation.
// Each stage stalls only when it holds data its successor cannot take, so
// bubbles collapse and a stall on m_ never drops or repeats a beat.
module euler_yxz_view_matrix (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// pos_x, pos_y, pos_z, angle_yaw, angle_pitch, angle_roll
	input  logic [eyvm_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// right_x/y/z, up_x/y/z, fwd_x/y/z, shift_x, shift_y, shift_z
	output logic [eyvm_pkg::OUT_TDATA_W-1:0]   m_tdata
);
	localparam int CB = eyvm_pkg::COORD_BITS;
	localparam int AB = eyvm_pkg::ANGLE_BITS;
	localparam int NS = eyvm_pkg::NSTAGE;

	eyvm_pkg::stage_en_t  en;
	logic [NS-1:0]        vld_q;
	eyvm_pkg::coord_vec_t pos_in;
	eyvm_pkg::coord_vec_t pos_s [10];
	logic [AB-1:0]        ang [3];
	logic [AB-1:0]        ang_cos [3];
	eyvm_pkg::rot_t       sn [3];
	eyvm_pkg::rot_t       cs [3];
	eyvm_pkg::rot_vec_t   rot_s10, rot_s12;
	eyvm_pkg::coord_vec_t shift_s12;

	// unpack the input beat
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pos_in[i]  = s_tdata[CB*i +: CB];
			ang[i]     = s_tdata[3*CB + AB*i +: AB];
			ang_cos[i] = ang[i] + AB'(1 << (AB - 2));
		end
	end

	// a stage advances when it is empty or its successor advances
	always_comb begin
		en[NS-1] = !vld_q[NS-1] || m_tready;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) vld_q[0] <= s_tvalid;
			for (int k = 1; k < NS; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// carry the position alongside the angle work
	always_ff @(posedge clk) begin
		if (en[0]) pos_s[0] <= pos_in;
		for (int k = 1; k < 10; k++) begin
			if (en[k]) pos_s[k] <= pos_s[k-1];
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_trig
		eyvm_sine u_sin (.clk(clk), .en(en[6:0]), .phase(ang[g]),     .value(sn[g]));
		eyvm_sine u_cos (.clk(clk), .en(en[6:0]), .phase(ang_cos[g]), .value(cs[g]));
	end

	eyvm_rot u_rot (
		.clk(clk), .en(en[9:7]),
		.s1(sn[0]), .c1(cs[0]), .s2(sn[1]), .c2(cs[1]), .s3(sn[2]), .c3(cs[2]),
		.rot(rot_s10)
	);

	eyvm_shift u_shift (
		.clk(clk), .en(en[11:10]), .rot_in(rot_s10), .pos(pos_s[9]),
		.rot_out(rot_s12), .shift(shift_s12)
	);

	assign s_tready = en[0];
	assign m_tvalid = vld_q[NS-1];
	assign m_tdata  = eyvm_pkg::OUT_TDATA_W'({shift_s12, rot_s12});

endmodule

/* design/eyvm_check.sv */
module eyvm_check (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [eyvm_pkg::IN_TDATA_W-1:0]  s_tdata,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [eyvm_pkg::OUT_TDATA_W-1:0] m_tdata
);
	// a held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// an empty output lets every stage advance, so input is open
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output");

	// forward y is minus the pitch sine: always within one
	a_fwdy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[127:112]) <= 16'sd16384 &&
			$signed(m_tdata[127:112]) >= -16'sd16384))
		else $error("forward y out of range");

	// up y is the pitch cosine times the roll cosine: always within one
	a_upy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[79:64]) <= 16'sd16384 &&
			$signed(m_tdata[79:64]) >= -16'sd16384))
		else $error("up y out of range");
endmodule

bind euler_yxz_view_matrix eyvm_check u_eyvm_check (.*);
